// ===== sv/assert_macros.svh =====
// Assertion macros shared by the q4 gate/up engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define QGU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked in every cycle, reset included
`define QGU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/qgu_pkg.sv =====
// Types, constants and float helpers for the q4 gate/up dot-product engine
`default_nettype none

package qgu_pkg;

  localparam int Rows       = 32;
  localparam int RowW       = 5;
  localparam int RowLength  = 256;
  localparam int BlockElems = 32;
  localparam int Blocks     = RowLength / BlockElems;
  localparam int ActDepth   = 4096;
  localparam int AccW       = 64;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    FPU_MUL,
    FPU_MUL_BF,
    FPU_ADD
  } fpu_op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] act_index;
    logic [15:0] act_value;
    logic [11:0] act_base;
    logic [4:0]  row;
    logic [2:0]  block;
    logic [3:0]  lane;
    logic [7:0]  gate_byte;
    logic [7:0]  up_byte;
    logic [15:0] gate_scale;
    logic [15:0] up_scale;
  } in_req_t;

  typedef struct packed {
    logic [4:0]  out_row;
    logic [31:0] gate_total;
    logic [31:0] up_total;
  } out_rsp_t;

  // Flush subnormals to signed zero, canonicalize NaN
  function automatic logic [31:0] tidy(input logic [31:0] u);
    logic [31:0] r;
    r = u;
    if (u[30:23] == 8'd0) begin
      r = {u[31], 31'd0};
    end else if (u[30:23] == 8'hFF && u[22:0] != 23'd0) begin
      r = CanonNan;
    end
    return r;
  endfunction

  function automatic logic [31:0] bf16_to_fp32(input logic [15:0] h);
    return tidy({h, 16'd0});
  endfunction

  // Signed 4-bit weight as an exact fp32 value
  function automatic logic [31:0] nibble_to_fp32(input logic [3:0] n);
    logic [3:0]  mag;
    logic [30:0] m;
    mag = n[3] ? 4'(-n) : n;
    case (mag)
      4'd0:    m = 31'h0000_0000;
      4'd1:    m = 31'h3F80_0000;
      4'd2:    m = 31'h4000_0000;
      4'd3:    m = 31'h4040_0000;
      4'd4:    m = 31'h4080_0000;
      4'd5:    m = 31'h40A0_0000;
      4'd6:    m = 31'h40C0_0000;
      4'd7:    m = 31'h40E0_0000;
      4'd8:    m = 31'h4100_0000;
      default: m = 31'h0000_0000;
    endcase
    return {n[3] && (mag != 4'd0), m};
  endfunction

endpackage

`default_nettype wire

// ===== sv/qgu_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none

module qgu_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/qgu_fpu.sv =====
// Shared fp32 multiply / add unit with flush-to-zero and optional bf16 rounding
`default_nettype none

module qgu_fpu (
  input  wire qgu_pkg::fpu_op_e op_i,
  input  wire logic [31:0]      a_i,
  input  wire logic [31:0]      b_i,
  output      logic [31:0]      res_o
);

  logic [31:0] a, b;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  // multiply path
  logic        m_sign;
  logic [47:0] m_prod, m_norm, m_man;
  logic signed [9:0] m_exp;
  logic [7:0]  m_ef;
  logic [5:0]  m_sh;
  logic [95:0] m_wide;
  logic        m_stk, m_rnd;
  logic [30:0] m_comb;
  logic [31:0] m_res, bf_sum, bf_res;

  // add path
  logic [31:0] big, sml;
  logic        sub;
  logic [7:0]  d;
  logic [5:0]  al_sh;
  logic [53:0] al_wide;
  logic [26:0] al_sml;
  logic [27:0] sum, sum_n;
  logic [4:0]  lz;
  logic        lz_found;
  logic signed [9:0] s_exp;
  logic [7:0]  s_ef;
  logic [4:0]  s_shl;
  logic        s_rnd;
  logic [30:0] s_comb;
  logic [31:0] s_res;

  // operand classification
  always_comb begin
    a      = qgu_pkg::tidy(a_i);
    b      = qgu_pkg::tidy(b_i);
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:23] == 8'd0);
    b_zero = (b[30:23] == 8'd0);
  end

  // fp32 multiply, rounded nearest-even with gradual underflow then flushed
  always_comb begin
    m_sign = a[31] ^ b[31];
    m_prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    m_exp  = $signed({2'b00, a[30:23]}) + $signed({2'b00, b[30:23]}) - 10'sd127;
    if (m_prod[47]) begin
      m_norm = m_prod;
      m_exp  = m_exp + 10'sd1;
    end else begin
      m_norm = m_prod << 1;
    end
    if (m_exp <= 10'sd0) begin
      m_sh = (m_exp < -10'sd46) ? 6'd48 : 6'(10'sd1 - m_exp);
      m_ef = 8'd0;
    end else begin
      m_sh = 6'd0;
      m_ef = m_exp[7:0];
    end
    m_wide = {m_norm, 48'd0} >> m_sh;
    m_man  = m_wide[95:48];
    m_stk  = |m_wide[47:0];
    m_comb = {m_ef, m_man[46:24]};
    m_rnd  = m_man[23] & ((|m_man[22:0]) | m_stk | m_comb[0]);
    m_comb = m_comb + 31'(m_rnd);
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      m_res = qgu_pkg::CanonNan;
    end else if (a_inf || b_inf || m_exp >= 10'sd255) begin
      m_res = {m_sign, 8'hFF, 23'd0};
    end else if (a_zero || b_zero || m_comb[30:23] == 8'd0) begin
      m_res = {m_sign, 31'd0};
    end else begin
      m_res = {m_sign, m_comb};
    end
  end

  // bf16 rounding of the product
  always_comb begin
    bf_sum = m_res + 32'h0000_7FFF + {31'd0, m_res[16]};
    if (m_res[30:23] == 8'hFF && m_res[22:0] != 23'd0) begin
      bf_res = qgu_pkg::CanonNan;
    end else begin
      bf_res = qgu_pkg::tidy({bf_sum[31:16], 16'd0});
    end
  end

  // fp32 add: align, add, normalize, round
  always_comb begin
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    sub     = a[31] ^ b[31];
    d       = big[30:23] - sml[30:23];
    al_sh   = (d > 8'd31) ? 6'd31 : 6'(d);
    al_wide = {1'b1, sml[22:0], 3'd0, 27'd0} >> al_sh;
    al_sml  = al_wide[53:27] | {26'd0, |al_wide[26:0]};
    if (sub) begin
      sum = {1'b0, 1'b1, big[22:0], 3'd0} - {1'b0, al_sml};
    end else begin
      sum = {1'b0, 1'b1, big[22:0], 3'd0} + {1'b0, al_sml};
    end
    lz       = 5'd0;
    lz_found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!lz_found && sum[i]) begin
        lz       = 5'(27 - i);
        lz_found = 1'b1;
      end
    end
    s_exp = $signed({2'b00, big[30:23]}) + 10'sd1 - $signed({5'd0, lz});
    if (s_exp >= 10'sd1) begin
      s_shl = lz;
      s_ef  = s_exp[7:0];
    end else begin
      s_shl = big[27:23];
      s_ef  = 8'd0;
    end
    sum_n  = sum << s_shl;
    s_comb = {s_ef, sum_n[26:4]};
    s_rnd  = sum_n[3] & ((|sum_n[2:0]) | s_comb[0]);
    s_comb = s_comb + 31'(s_rnd);
    if (a_nan || b_nan || (a_inf && b_inf && sub)) begin
      s_res = qgu_pkg::CanonNan;
    end else if (a_inf) begin
      s_res = a;
    end else if (b_inf) begin
      s_res = b;
    end else if (a_zero && b_zero) begin
      s_res = {a[31] & b[31], 31'd0};
    end else if (a_zero) begin
      s_res = b;
    end else if (b_zero) begin
      s_res = a;
    end else if (sum == 28'd0) begin
      s_res = 32'd0;
    end else if (s_exp >= 10'sd255) begin
      s_res = {big[31], 8'hFF, 23'd0};
    end else if (s_comb[30:23] == 8'd0) begin
      s_res = {big[31], 31'd0};
    end else begin
      s_res = {big[31], s_comb};
    end
  end

  // result select
  always_comb begin
    case (op_i)
      qgu_pkg::FPU_MUL:    res_o = m_res;
      qgu_pkg::FPU_MUL_BF: res_o = bf_res;
      qgu_pkg::FPU_ADD:    res_o = s_res;
      default:             res_o = s_res;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/q4_gate_up_dot_accumulate.sv =====
// Top level: fused gate/up q4 dot-product engine over an activation RAM and accumulator RAM
//
//   channel | direction | handshake                 | payload
//   request | in        | in_valid_i / in_ready_o   | in_req_i  (qgu_pkg::in_req_t)
//   result  | out       | out_valid_o / out_ready_i | out_rsp_o (qgu_pkg::out_rsp_t)
//
// Load and clear requests are handled on acceptance. A weight-byte request is accepted, then
// passes through ST_RD0, ST_RD1 and ST_RD2 for the two activation reads and the accumulator read on the
// single read port of each RAM, twelve steps through the one shared fp unit, and one write-back.
// Reset clears the FSM, the output valid flag and the per-row accumulator valid bits
// (an invalid row reads as +0.0). Write-back waits while the output register is full.
`default_nettype none
`include "assert_macros.svh"

module q4_gate_up_dot_accumulate (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire qgu_pkg::in_req_t  in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      qgu_pkg::out_rsp_t out_rsp_o
);

  typedef enum logic [3:0] {
    STEP_WG0, STEP_WG1, STEP_WU0, STEP_WU1,
    STEP_PG0, STEP_PG1, STEP_PU0, STEP_PU1,
    STEP_SG,  STEP_SU,  STEP_ACCG, STEP_ACCU
  } calc_step_e;

  qgu_pkg::state_e   state_q, state_d;
  calc_step_e        step_q;
  logic [qgu_pkg::Rows-1:0] vld_q;
  logic              out_valid_q;
  qgu_pkg::out_rsp_t out_rsp_q;

  qgu_pkg::in_req_t  req_q;
  logic [11:0]       addr_q;
  logic [31:0]       x0_q, x1_q, accg_q, accu_q;
  logic [31:0]       a0_q, a1_q, b0_q, b1_q;

  logic              accept, row_ok, blk_ok, start_mac, done_go;
  logic              act_we, act_re, acc_re;
  logic [11:0]       act_raddr;
  logic [15:0]       act_rdata;
  logic [qgu_pkg::AccW-1:0] acc_rdata;
  qgu_pkg::fpu_op_e  fpu_op;
  logic [31:0]       fpu_a, fpu_b, fpu_res;
  logic [31:0]       sg_fp, su_fp;

  assign accept    = in_valid_i && in_ready_o;
  assign row_ok    = int'(in_req_i.row) < qgu_pkg::Rows;
  assign blk_ok    = int'(in_req_i.block) < qgu_pkg::Blocks;
  assign start_mac = accept && (in_req_i.opcode == qgu_pkg::OP_MAC) && row_ok && blk_ok;
  assign done_go   = (state_q == qgu_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  assign sg_fp     = qgu_pkg::bf16_to_fp32(req_q.gate_scale);
  assign su_fp     = qgu_pkg::bf16_to_fp32(req_q.up_scale);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qgu_pkg::ST_IDLE: if (start_mac) state_d = qgu_pkg::ST_RD0;
      qgu_pkg::ST_RD0:  state_d = qgu_pkg::ST_RD1;
      qgu_pkg::ST_RD1:  state_d = qgu_pkg::ST_RD2;
      qgu_pkg::ST_RD2:  state_d = qgu_pkg::ST_CALC;
      qgu_pkg::ST_CALC: if (step_q == STEP_ACCU) state_d = qgu_pkg::ST_DONE;
      qgu_pkg::ST_DONE: if (done_go) state_d = qgu_pkg::ST_IDLE;
      default:          state_d = qgu_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs: RAM controls
  always_comb begin
    in_ready_o = (state_q == qgu_pkg::ST_IDLE);
    act_we     = accept && (in_req_i.opcode == qgu_pkg::OP_LOAD);
    act_re     = (state_q == qgu_pkg::ST_RD0) || (state_q == qgu_pkg::ST_RD1);
    act_raddr  = (state_q == qgu_pkg::ST_RD1) ? addr_q + 12'd1 : addr_q;
    acc_re     = (state_q == qgu_pkg::ST_RD0);
  end

  // fp unit operand select per step
  always_comb begin
    case (step_q)
      STEP_WG0: begin
        fpu_op = qgu_pkg::FPU_MUL_BF;
        fpu_a = qgu_pkg::nibble_to_fp32(req_q.gate_byte[3:0]); fpu_b = sg_fp;
      end
      STEP_WG1: begin
        fpu_op = qgu_pkg::FPU_MUL_BF;
        fpu_a = qgu_pkg::nibble_to_fp32(req_q.gate_byte[7:4]); fpu_b = sg_fp;
      end
      STEP_WU0: begin
        fpu_op = qgu_pkg::FPU_MUL_BF;
        fpu_a = qgu_pkg::nibble_to_fp32(req_q.up_byte[3:0]); fpu_b = su_fp;
      end
      STEP_WU1: begin
        fpu_op = qgu_pkg::FPU_MUL_BF;
        fpu_a = qgu_pkg::nibble_to_fp32(req_q.up_byte[7:4]); fpu_b = su_fp;
      end
      STEP_PG0:  begin fpu_op = qgu_pkg::FPU_MUL; fpu_a = a0_q;   fpu_b = x0_q; end
      STEP_PG1:  begin fpu_op = qgu_pkg::FPU_MUL; fpu_a = a1_q;   fpu_b = x1_q; end
      STEP_PU0:  begin fpu_op = qgu_pkg::FPU_MUL; fpu_a = b0_q;   fpu_b = x0_q; end
      STEP_PU1:  begin fpu_op = qgu_pkg::FPU_MUL; fpu_a = b1_q;   fpu_b = x1_q; end
      STEP_SG:   begin fpu_op = qgu_pkg::FPU_ADD; fpu_a = a0_q;   fpu_b = a1_q; end
      STEP_SU:   begin fpu_op = qgu_pkg::FPU_ADD; fpu_a = b0_q;   fpu_b = b1_q; end
      STEP_ACCG: begin fpu_op = qgu_pkg::FPU_ADD; fpu_a = accg_q; fpu_b = a0_q; end
      STEP_ACCU: begin fpu_op = qgu_pkg::FPU_ADD; fpu_a = accu_q; fpu_b = b0_q; end
      default:   begin fpu_op = qgu_pkg::FPU_ADD; fpu_a = 32'd0;  fpu_b = 32'd0; end
    endcase
  end

  qgu_fpu u_fpu (
    .op_i  (fpu_op),
    .a_i   (fpu_a),
    .b_i   (fpu_b),
    .res_o (fpu_res)
  );

  qgu_ram #(
    .Width (16),
    .Depth (qgu_pkg::ActDepth)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (in_req_i.act_index),
    .wdata_i (in_req_i.act_value),
    .re_i    (act_re),
    .raddr_i (act_raddr),
    .rdata_o (act_rdata)
  );

  qgu_ram #(
    .Width (qgu_pkg::AccW),
    .Depth (qgu_pkg::Rows)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (done_go),
    .waddr_i (req_q.row),
    .wdata_i ({accg_q, accu_q}),
    .re_i    (acc_re),
    .raddr_i (req_q.row),
    .rdata_o (acc_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qgu_pkg::ST_IDLE;
      step_q      <= STEP_WG0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == qgu_pkg::ST_CALC) begin
        step_q <= (step_q == STEP_ACCU) ? STEP_WG0 : calc_step_e'(step_q + 4'd1);
      end
      if (accept && in_req_i.opcode == qgu_pkg::OP_CLEAR && row_ok) begin
        vld_q[in_req_i.row] <= 1'b0;
      end
      if (done_go) begin
        vld_q[req_q.row] <= 1'b1;
      end
      if (done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_mac) begin
      req_q  <= in_req_i;
      addr_q <= in_req_i.act_base + {4'd0, in_req_i.block, 5'd0} + {7'd0, in_req_i.lane, 1'b0};
    end
    if (state_q == qgu_pkg::ST_RD1) begin
      x0_q   <= qgu_pkg::bf16_to_fp32(act_rdata);
      accg_q <= vld_q[req_q.row] ? acc_rdata[63:32] : 32'd0;
      accu_q <= vld_q[req_q.row] ? acc_rdata[31:0] : 32'd0;
    end
    if (state_q == qgu_pkg::ST_RD2) begin
      x1_q <= qgu_pkg::bf16_to_fp32(act_rdata);
    end
    if (state_q == qgu_pkg::ST_CALC) begin
      case (step_q)
        STEP_WG0, STEP_PG0, STEP_SG: a0_q   <= fpu_res;
        STEP_WG1, STEP_PG1:          a1_q   <= fpu_res;
        STEP_WU0, STEP_PU0, STEP_SU: b0_q   <= fpu_res;
        STEP_WU1, STEP_PU1:          b1_q   <= fpu_res;
        STEP_ACCG:                   accg_q <= fpu_res;
        STEP_ACCU:                   accu_q <= fpu_res;
        default:                     a0_q   <= a0_q;
      endcase
    end
    if (done_go) begin
      out_rsp_q.out_row    <= req_q.row;
      out_rsp_q.gate_total <= accg_q;
      out_rsp_q.up_total   <= accu_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // checks
  `QGU_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q) == qgu_pkg::ST_DONE, "result without write-back")
  `QGU_ASSERT(a_done_to_idle, done_go |=> state_q == qgu_pkg::ST_IDLE, "write-back did not return to idle")
  `QGU_ASSERT(a_step_idle, state_q != qgu_pkg::ST_CALC |-> step_q == STEP_WG0, "step counter not parked")
  `QGU_ASSERT_ALWAYS(a_rst_out, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

`default_nettype wire
